// File: sv/lrc_pkg.sv
// Package for the LRU resource cache directory: opcodes, status codes, widths.
// No dependencies.
`default_nettype none
package lrc_pkg;
	localparam int FUNC_W = 2;
	localparam int KEY_W = 32;
	localparam int REQ_W = 24;
	localparam int STATUS_W = 3;
	localparam int SLOT_W = 6;
	localparam int REFS_W = 16;
	localparam int BYTES_W = 25;
	localparam int OCC_W = 7;
	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 2'd0,
		FN_FIND  = 2'd1,
		FN_EVICT = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 3'd0,
		ST_INSERT   = 3'd1,
		ST_INS_EVIC = 3'd2,
		ST_MISS     = 3'd3,
		ST_EVICTED  = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	// Request queued from the front part to the back part.
	typedef struct packed {
		func_t             func;
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] bytes;
	} req_t;

	// Result item.
	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [REFS_W-1:0]  refs;
		logic [BYTES_W-1:0] bytes;
		logic [KEY_W-1:0]   victim;
		logic [OCC_W-1:0]   occ;
	} rsp_t;

	// Round a byte count up to a multiple of 32.
	function automatic logic [BYTES_W-1:0] align32(input logic [REQ_W-1:0] sz);
		logic [BYTES_W-1:0] s;
		s = {1'b0, sz} + BYTES_W'(31);
		return {s[BYTES_W-1:5], 5'b0};
	endfunction
endpackage
`default_nettype wire

// File: sv/lrc_front.sv
// Front part: takes input transfers, decodes the opcode, aligns the size and
// pushes a request into a two-entry queue. Depends on lrc_pkg.
`default_nettype none
module lrc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid,
	output logic                            stall,
	input  wire logic [lrc_pkg::FUNC_W-1:0] func,
	input  wire logic [lrc_pkg::KEY_W-1:0]  resource_id,
	input  wire logic [lrc_pkg::REQ_W-1:0]  request_size,
	output logic                            req_valid,
	output lrc_pkg::req_t                   req,
	input  wire logic                       req_pop
);
	import lrc_pkg::*;

	req_t        mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign req_valid = (cnt_q != 2'd0);
	assign req = mem_q[rd_q];

	// Queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{func: func_t'(func), key: resource_id,
				bytes: align32(request_size)};
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (req_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(req_pop);
		end
	end
endmodule
`default_nettype wire

// File: sv/lrc_back.sv
// Back part: pipelined scan over the entry table to look up, age ranks and
// pick the least recent entry, then updates and emits one result. Also holds
// the generic registered-read RAM used for the entry table. Depends on lrc_pkg.
`default_nettype none
module lrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_data_q <= mem_q[rd_addr];
	end
endmodule

module lrc_back #(
	parameter int ENTRY_COUNT = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	input  lrc_pkg::req_t req,
	output logic       req_pop,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output lrc_pkg::rsp_t rsp
);
	import lrc_pkg::*;

	localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CW = $clog2(ENTRY_COUNT + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DEC   = 5'b00100,
		S_AGE   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	// One word of the entry table
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] bytes;
		logic [REFS_W-1:0]  refs;
	} entry_t;

	state_t state_q;
	logic [ENTRY_COUNT-1:0] valid_q;
	logic [CW-1:0]      live_q;

	req_t    r_q;
	logic [CW-1:0] idx_q;
	logic    hit_q, free_q, lru_ok_q;
	logic [IW-1:0] hit_i_q, free_i_q, lru_i_q, lru_r_q, hit_r_q;
	logic [REFS_W-1:0]  hit_refs_q;
	logic [BYTES_W-1:0] hit_bytes_q;
	logic [KEY_W-1:0]   lru_key_q;
	// Age step: entries with rank below thr_q (or all if age_all_q) advance.
	logic [IW-1:0] thr_q, tgt_q;
	logic    age_all_q;
	rsp_t    out_q;

	// Read pipeline: entry under test lags the address by the registered RAM read
	logic          chk_s1, age_s1;
	logic [IW-1:0] i_s1;

	// Table RAM ports
	entry_t        ent_rd, ent_wr;
	logic          ent_wr_en;
	logic [IW-1:0] ent_wr_addr;
	logic [IW-1:0] rank_rd, rank_wr;
	logic          rank_wr_en;

	// Decision for the current request
	rsp_t          dec_rsp;
	logic          dec_age, dec_all;
	logic [IW-1:0] dec_thr, dec_tgt, ins_i;
	logic [REFS_W-1:0] new_refs;

	logic [IW-1:0] i;
	assign i = idx_q[IW-1:0];
	assign req_pop = (state_q == S_IDLE) && req_valid;
	assign rsp_valid = (state_q == S_OUT);
	assign rsp = out_q;

	lrc_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRY_COUNT)) u_ent_ram (
		.clk, .wr_en(ent_wr_en), .wr_addr(ent_wr_addr), .wr_data(ent_wr),
		.rd_addr(i), .rd_data(ent_rd)
	);

	lrc_ram #(.WIDTH(IW), .DEPTH(ENTRY_COUNT)) u_rank_ram (
		.clk, .wr_en(rank_wr_en), .wr_addr(i_s1), .wr_data(rank_wr),
		.rd_addr(i), .rd_data(rank_rd)
	);

	// Rank update: target becomes most recent, valid entries below thr_q (or all, if age_all_q) age
	assign rank_wr_en = age_s1 && ((i_s1 == tgt_q) ||
		(valid_q[i_s1] && (age_all_q || rank_rd < thr_q)));
	assign rank_wr = (i_s1 == tgt_q) ? '0 : rank_rd + IW'(1);

	// Result, table write and aging plan from the scan results
	always_comb begin
		dec_rsp = '{status: ST_MISS, slot: '0, refs: '0, bytes: '0,
			victim: '0, occ: OCC_W'(live_q)};
		dec_age = 1'b0;
		dec_all = 1'b0;
		dec_thr = '0;
		dec_tgt = '0;
		ent_wr_en = 1'b0;
		ent_wr_addr = '0;
		ent_wr = '0;
		new_refs = (r_q.func == FN_ALLOC && hit_refs_q != REFS_MAX) ?
			hit_refs_q + REFS_W'(1) : hit_refs_q;
		ins_i = free_q ? free_i_q : lru_i_q;
		case (r_q.func)
			FN_ALLOC, FN_FIND: begin
				if (hit_q) begin
					dec_rsp.status = ST_HIT;
					dec_rsp.slot = SLOT_W'(hit_i_q);
					dec_rsp.refs = new_refs;
					dec_rsp.bytes = hit_bytes_q;
					dec_age = 1'b1;
					dec_thr = hit_r_q;
					dec_tgt = hit_i_q;
					ent_wr_en = (state_q == S_DEC) && (r_q.func == FN_ALLOC);
					ent_wr_addr = hit_i_q;
					ent_wr = '{key: r_q.key, bytes: hit_bytes_q, refs: new_refs};
				end else if (r_q.func == FN_ALLOC) begin
					dec_rsp.status = free_q ? ST_INSERT : ST_INS_EVIC;
					dec_rsp.slot = SLOT_W'(ins_i);
					dec_rsp.refs = REFS_W'(1);
					dec_rsp.bytes = r_q.bytes;
					dec_rsp.victim = free_q ? '0 : lru_key_q;
					dec_rsp.occ = OCC_W'(free_q ? live_q + CW'(1) : live_q);
					dec_age = 1'b1;
					dec_all = 1'b1;
					dec_tgt = ins_i;
					ent_wr_en = (state_q == S_DEC);
					ent_wr_addr = ins_i;
					ent_wr = '{key: r_q.key, bytes: r_q.bytes, refs: REFS_W'(1)};
				end
			end
			FN_EVICT: begin
				if (lru_ok_q) begin
					dec_rsp.status = ST_EVICTED;
					dec_rsp.slot = SLOT_W'(lru_i_q);
					dec_rsp.victim = lru_key_q;
					dec_rsp.occ = OCC_W'(live_q - CW'(1));
				end else begin
					dec_rsp.status = ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	// Scan bookkeeping and captured decision
	always_ff @(posedge clk) begin
		i_s1 <= i;
		if (state_q == S_IDLE) begin
			r_q <= req;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			lru_ok_q <= 1'b0;
			hit_i_q <= '0;
			free_i_q <= '0;
			lru_i_q <= '0;
			lru_r_q <= '0;
		end else if (chk_s1) begin
			// One entry a cycle: match, first free slot, oldest entry
			if (valid_q[i_s1]) begin
				if (!hit_q && ent_rd.key == r_q.key) begin
					hit_q <= 1'b1;
					hit_i_q <= i_s1;
					hit_r_q <= rank_rd;
					hit_refs_q <= ent_rd.refs;
					hit_bytes_q <= ent_rd.bytes;
				end
				if (!lru_ok_q || rank_rd > lru_r_q) begin
					lru_ok_q <= 1'b1;
					lru_i_q <= i_s1;
					lru_r_q <= rank_rd;
					lru_key_q <= ent_rd.key;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
				free_i_q <= i_s1;
			end
		end
		if (state_q == S_DEC) begin
			out_q <= dec_rsp;
			thr_q <= dec_thr;
			tgt_q <= dec_tgt;
			age_all_q <= dec_all;
		end
	end

	// Control and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			live_q <= '0;
			idx_q <= '0;
			chk_s1 <= 1'b0;
			age_s1 <= 1'b0;
		end else begin
			chk_s1 <= (state_q == S_SCAN) && (idx_q < CW'(ENTRY_COUNT));
			age_s1 <= (state_q == S_AGE) && (idx_q < CW'(ENTRY_COUNT));
			case (state_q)
				S_IDLE: if (req_valid) begin
					idx_q <= '0;
					state_q <= S_SCAN;
				end
				// Addresses 0..N-1, then address N while the last entry is still checked
				S_SCAN: begin
					if (idx_q == CW'(ENTRY_COUNT)) begin
						idx_q <= '0;
						state_q <= S_DEC;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DEC: begin
					state_q <= dec_age ? S_AGE : S_OUT;
					if (r_q.func == FN_ALLOC && !hit_q && free_q) begin
						valid_q[free_i_q] <= 1'b1;
						live_q <= live_q + CW'(1);
					end else if (r_q.func == FN_EVICT && lru_ok_q) begin
						valid_q[lru_i_q] <= 1'b0;
						live_q <= live_q - CW'(1);
					end
				end
				S_AGE: begin
					if (idx_q == CW'(ENTRY_COUNT)) begin
						idx_q <= '0;
						state_q <= S_OUT;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_OUT: if (!rsp_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/lru_resource_cache_directory.sv
// Top level of the LRU resource cache directory: front queue and back engine.
// Depends on lrc_pkg, lrc_front, lrc_back.
//
// Fully associative directory with LRU replacement. Each request is queued by
// the front part (up to two waiting, in_stall while both are taken), then the
// back engine walks every entry once through a registered-read table RAM to
// look up the key, find the lowest free slot and the least recent entry, and
// walks them again to update recency ranks. Both walks visit one entry per
// cycle, each with an extra step for the RAM read; find misses, unused
// opcodes and evicts skip the second walk. The result is held until taken.
`default_nettype none
module lru_resource_cache_directory #(
	parameter int ENTRY_COUNT = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [lrc_pkg::FUNC_W-1:0]    func,
	input  wire logic [lrc_pkg::KEY_W-1:0]     resource_id,
	input  wire logic [lrc_pkg::REQ_W-1:0]     request_size,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [lrc_pkg::STATUS_W-1:0]       status,
	output logic [lrc_pkg::SLOT_W-1:0]         slot,
	output logic [lrc_pkg::REFS_W-1:0]         ref_count,
	output logic [lrc_pkg::BYTES_W-1:0]        aligned_size,
	output logic [lrc_pkg::KEY_W-1:0]          victim_id,
	output logic [lrc_pkg::OCC_W-1:0]          occupancy
);
	import lrc_pkg::*;

	logic req_valid, req_pop;
	req_t req;
	rsp_t rsp;

	lrc_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall), .func,
		.resource_id, .request_size, .req_valid, .req, .req_pop
	);

	lrc_back #(.ENTRY_COUNT(ENTRY_COUNT)) u_back (
		.clk, .arst_n, .req_valid, .req, .req_pop,
		.rsp_valid(out_valid), .rsp_stall(out_stall), .rsp
	);

	assign status = rsp.status;
	assign slot = rsp.slot;
	assign ref_count = rsp.refs;
	assign aligned_size = rsp.bytes;
	assign victim_id = rsp.victim;
	assign occupancy = rsp.occ;
endmodule
`default_nettype wire
